FILE: rtl/indexed_circular_deque_unit_assert.svh
// assertion macros used by the checker file
`ifndef INDEXED_CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define INDEXED_CIRCULAR_DEQUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ICDU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, sampled on clk, live during rst
`define ICDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

FILE: rtl/icd_pkg.sv
`default_nettype none

package icd_pkg;

  // sizing
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 7;
  localparam int VAL_W      = 32;
  localparam int FILL_W     = 7;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_MOVE
  } state_t;

  // store access request: one write port, one read port
  typedef struct packed {
    logic  we;
    ptr_t  wr_addr;
    data_t wr_data;
    ptr_t  rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/icd_store.sv
`default_nettype none

module icd_store
  import icd_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output data_t         rdata
);

  data_t mem [CAPACITY];

  // synchronous write, registered read (old data on same-address overlap)
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rdata <= mem[req.rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/icd_ctrl.sv
`default_nettype none

module icd_ctrl
  import icd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation,
  input  wire logic [POS_W-1:0]    position,
  input  wire logic signed [VAL_W-1:0] new_value,
  output logic                     done,
  output logic signed [VAL_W-1:0]  read_value,
  output logic [FILL_W-1:0]        fill_count,
  output logic [1:0]               status,
  output mem_req_t                 mem_req,
  input  wire data_t               mem_rdata
);

  // circular slot arithmetic
  function automatic ptr_t slot_step(input ptr_t p, input logic up);
    ptr_t r;
    if (up) begin
      r = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    end else begin
      r = (p == '0) ? PTR_W'(CAPACITY - 1) : p - PTR_W'(1);
    end
    return r;
  endfunction

  function automatic ptr_t slot_add(input ptr_t a, input ptr_t b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W + 1)'(CAPACITY)) begin
      s = s - (PTR_W + 1)'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic data_t to_store(input logic [VAL_W-1:0] v);
    logic [VAL_W+63:0] ext;
    ext = {{64{v[VAL_W-1]}}, v};
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] to_port(input data_t d);
    logic [DATA_WIDTH+VAL_W-1:0] ext;
    ext = {{VAL_W{1'b0}}, d};
    return ext[VAL_W-1:0];
  endfunction

  state_t state, state_next;
  ptr_t   head;
  cnt_t   count;
  logic   done_next;

  // latched request and move engine
  op_t    op_r;
  data_t  val_r;
  ptr_t   wr_slot;
  ptr_t   rd_slot;
  cnt_t   left;
  logic   pend;
  logic   up_r;
  logic   front_r;

  // request decode in idle
  op_t              op_in;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic [CMP_W-1:0] moves_c;
  status_t          chk;
  logic             is_ins;
  logic             front;
  logic             up;
  ptr_t             base;
  ptr_t             d0;
  ptr_t             phys;
  logic             finish;
  cnt_t             count_new;
  logic [CMP_W-1:0] count_new_c;

  assign op_in = op_t'(operation);
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count);
  assign is_ins = (op_in == OP_INSERT);
  assign front = (pos_c < (cnt_c >> 1));
  assign up = is_ins ? front : !front;
  assign base = (is_ins && front) ? slot_step(head, 1'b0) : head;

  // range and capacity checks, full before range on insert
  always_comb begin
    if (is_ins) begin
      if (cnt_c == CMP_W'(CAPACITY)) begin
        chk = STAT_FULL;
      end else if (pos_c > cnt_c) begin
        chk = STAT_RANGE;
      end else begin
        chk = STAT_OK;
      end
    end else begin
      if (count == '0) begin
        chk = STAT_EMPTY;
      end else if (pos_c >= cnt_c) begin
        chk = STAT_RANGE;
      end else begin
        chk = STAT_OK;
      end
    end
  end

  // first destination slot and number of moves on the side picked by the half-count compare
  always_comb begin
    if (is_ins) begin
      d0      = front ? '0 : count[PTR_W-1:0];
      moves_c = front ? pos_c : cnt_c - pos_c;
    end else begin
      d0      = pos_c[PTR_W-1:0];
      moves_c = front ? pos_c : cnt_c - pos_c - CMP_W'(1);
    end
  end

  assign phys = slot_add(base, d0);

  // engine drained: all moves written back
  assign finish = (state == S_MOVE) && (left == '0) && !pend;
  assign count_new = (op_r == OP_INSERT) ? count + CNT_W'(1) : count - CNT_W'(1);
  assign count_new_c = CMP_W'(count_new);

  assign busy = (state != S_IDLE);

  // next state and store access
  always_comb begin
    state_next       = state;
    done_next        = 1'b0;
    mem_req.we       = 1'b0;
    mem_req.wr_addr  = wr_slot;
    mem_req.wr_data  = val_r;
    mem_req.rd_addr  = rd_slot;
    unique case (state)
      S_IDLE: begin
        mem_req.rd_addr = phys;
        if (start) begin
          if (chk != STAT_OK) begin
            done_next = 1'b1;
          end else if (is_ins) begin
            state_next = S_MOVE;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        mem_req.we = (op_r == OP_SET);
        if (op_r == OP_REMOVE) begin
          state_next = S_MOVE;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MOVE: begin
        if (pend) begin
          mem_req.we      = 1'b1;
          mem_req.wr_data = mem_rdata;
        end else if (finish) begin
          mem_req.we = (op_r == OP_INSERT);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // pointers, count and move engine
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (start) begin
            op_r    <= op_in;
            val_r   <= to_store(new_value);
            wr_slot <= phys;
            rd_slot <= slot_step(phys, up);
            left    <= moves_c[CNT_W-1:0];
            up_r    <= up;
            front_r <= front;
            if (chk != STAT_OK) begin
              read_value <= '0;
              fill_count <= cnt_c[FILL_W-1:0];
              status     <= chk;
            end
          end
        end
        S_LOOKUP: begin
          read_value <= to_port(mem_rdata);
          fill_count <= cnt_c[FILL_W-1:0];
          status     <= STAT_OK;
        end
        S_MOVE: begin
          pend <= (left != '0);
          if (left != '0) begin
            rd_slot <= slot_step(rd_slot, up_r);
            left    <= left - CNT_W'(1);
          end
          if (pend) begin
            wr_slot <= slot_step(wr_slot, up_r);
          end
          if (finish) begin
            count      <= count_new;
            fill_count <= count_new_c[FILL_W-1:0];
            status     <= STAT_OK;
            if (op_r == OP_INSERT) begin
              read_value <= '0;
            end
            if (front_r) begin
              head <= slot_step(head, op_r != OP_INSERT);
            end
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/indexed_circular_deque_unit.sv
// channel   | signals                              | handshake
// ----------+--------------------------------------+----------------------------
// request   | operation, position, new_value       | start high while busy low
// result    | read_value, fill_count, status       | done high for one cycle
//
// rejected requests (full, empty, out of range) answer in the cycle after accept
// get and set: accept, then the registered store read
// insert goes straight to the move state; remove reads in lookup, then moves;
// the side picked by comparing position to half the count moves; one element moves a cycle
// rst is synchronous and empties the deque; the store itself is not cleared
// the receiver cannot stall; a result shows while the next request is taken
`default_nettype none

module indexed_circular_deque_unit
  import icd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              operation,
  input  wire logic [POS_W-1:0]        position,
  input  wire logic signed [VAL_W-1:0] new_value,
  output logic                         done,
  output logic signed [VAL_W-1:0]      read_value,
  output logic [FILL_W-1:0]            fill_count,
  output logic [1:0]                   status
);

  mem_req_t mem_req;
  data_t    mem_rdata;

  // sequencer: checks, pointers and move engine
  icd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .position   (position),
    .new_value  (new_value),
    .done       (done),
    .read_value (read_value),
    .fill_count (fill_count),
    .status     (status),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  // element store
  icd_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/icd_checker.sv
`default_nettype none
`include "indexed_circular_deque_unit_assert.svh"

module icd_checker
  import icd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    busy,
  input wire logic                    done,
  input wire logic signed [VAL_W-1:0] read_value,
  input wire logic [FILL_W-1:0]       fill_count,
  input wire logic [1:0]              status
);

  // reset leaves the unit idle with no result
  `ICDU_ASSERT_NEXT(a_reset_idle, rst, !busy && !done)

  // a rejected request returns zero
  `ICDU_ASSERT_NOW(a_reject_zero, done && (status != STAT_OK), read_value == '0)

  // full is reported only at capacity
  `ICDU_ASSERT_NOW(a_full_count, done && (status == STAT_FULL), fill_count == FILL_W'(CAPACITY))

  // empty is reported only with nothing held
  `ICDU_ASSERT_NOW(a_empty_count, done && (status == STAT_EMPTY), fill_count == '0)

endmodule

bind indexed_circular_deque_unit icd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .done       (done),
  .read_value (read_value),
  .fill_count (fill_count),
  .status     (status)
);

`default_nettype wire

FILE: tb/sv/tb_indexed_circular_deque_unit.sv
`default_nettype none

module tb_indexed_circular_deque_unit
  import icd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HIGH       = 6;
  localparam int CLK_LOW        = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct {
    logic [VAL_W-1:0]  rd;
    logic [FILL_W-1:0] fill;
    status_t           st;
  } deque_result_t;

  typedef struct {
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit               typed;
    deque_result_t    res;
  } deque_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              operation = OP_GET;
  logic [POS_W-1:0]        position = '0;
  logic signed [VAL_W-1:0] new_value = '0;
  logic                    busy;
  logic                    done;
  logic signed [VAL_W-1:0] read_value;
  logic [FILL_W-1:0]       fill_count;
  logic [1:0]              status;

  // shadow deque: store, head and count
  logic [DATA_WIDTH-1:0] shadow_store [CAPACITY];
  ptr_t                  shadow_head = '0;
  int                    shadow_count = 0;

  deque_result_t pending_results[$];
  deque_row_t    directed_rows[$];

  bit idle_enable = 1'b1;
  int error_count = 0;
  int stall_cycles = 0;
  int op_hits[4] = '{default: 0};
  int status_hits[4] = '{default: 0};
  int peak_count = 0;

  indexed_circular_deque_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .position   (position),
    .new_value  (new_value),
    .done       (done),
    .read_value (read_value),
    .fill_count (fill_count),
    .status     (status)
  );

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW clk = 1'b0;
  end

  // physical slot of a logical position
  function automatic ptr_t slot_of(int k);
    return ptr_t'((int'(shadow_head) + k) % CAPACITY);
  endfunction

  // apply one request to the shadow deque and work out its answer
  task automatic deque_apply(input op_t op, input int pos, input logic [VAL_W-1:0] val,
                             output deque_result_t res);
    int k;
    res.rd = '0;
    res.st = STAT_OK;
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.st = STAT_FULL;
      end else if (pos > shadow_count) begin
        res.st = STAT_RANGE;
      end else begin
        if (pos < shadow_count / 2) begin
          // front part moves down, head steps back with wrap
          shadow_head = shadow_head - 1'b1;
          for (k = 0; k < pos; k++) shadow_store[slot_of(k)] = shadow_store[slot_of(k + 1)];
        end else begin
          for (k = shadow_count; k > pos; k--)
            shadow_store[slot_of(k)] = shadow_store[slot_of(k - 1)];
        end
        shadow_store[slot_of(pos)] = val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.st = STAT_EMPTY;
    end else if (pos >= shadow_count) begin
      res.st = STAT_RANGE;
    end else begin
      res.rd = shadow_store[slot_of(pos)];
      if (op == OP_SET) begin
        shadow_store[slot_of(pos)] = val;
      end else if (op == OP_REMOVE) begin
        if (pos < shadow_count / 2) begin
          // front part moves up, head steps forward
          for (k = pos; k >= 1; k--) shadow_store[slot_of(k)] = shadow_store[slot_of(k - 1)];
          shadow_head = shadow_head + 1'b1;
        end else begin
          for (k = pos; k + 1 < shadow_count; k++)
            shadow_store[slot_of(k)] = shadow_store[slot_of(k + 1)];
        end
        shadow_count--;
      end
    end
    res.fill = FILL_W'(shadow_count);
  endtask

  // present one request, hold it until taken, then queue its answer
  task automatic send_request(input op_t op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val, input bit typed,
                              input deque_result_t typed_res);
    deque_result_t model_res;
    while (idle_enable && $urandom_range(99, 0) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    position  <= pos;
    new_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    deque_apply(op, int'(pos), val, model_res);
    pending_results.push_back(typed ? typed_res : model_res);
    op_hits[op]++;
    status_hits[model_res.st]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  function automatic void add_row(op_t op, int pos, logic [VAL_W-1:0] val, bit typed,
                                  logic [VAL_W-1:0] rd, int fill, status_t st);
    deque_row_t r;
    r.op       = op;
    r.pos      = POS_W'(pos);
    r.val      = val;
    r.typed    = typed;
    r.res.rd   = rd;
    r.res.fill = FILL_W'(fill);
    r.res.st   = st;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9, 0))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly legal positions, with the edges and some out-of-range noise
  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return POS_W'($urandom_range(shadow_count, 0));
    if (r < 80) return POS_W'(shadow_count);
    if (r < 88) return POS_W'((shadow_count > 0) ? shadow_count - 1 : 0);
    return POS_W'($urandom_range(127, 0));
  endfunction

  function automatic op_t pick_op(int insert_pct, int remove_pct);
    int r;
    r = $urandom_range(99, 0);
    if (r < insert_pct) return OP_INSERT;
    if (r < insert_pct + remove_pct) return OP_REMOVE;
    return ($urandom_range(1, 0) == 0) ? OP_GET : OP_SET;
  endfunction

  task automatic random_burst(int items, int insert_pct, int remove_pct);
    deque_result_t none;
    none.rd   = '0;
    none.fill = '0;
    none.st   = STAT_OK;
    repeat (items) send_request(pick_op(insert_pct, remove_pct), pick_position(),
                                pick_value(), 1'b0, none);
  endtask

  // result check against the oldest pending answer
  always @(posedge clk) begin
    deque_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("error: result with nothing pending: read %h fill %0d status %0d",
                   read_value, fill_count, status);
      end else begin
        exp_res = pending_results.pop_front();
        if (read_value !== exp_res.rd || fill_count !== exp_res.fill ||
            status !== exp_res.st) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS)
            $display("error: expected read %h fill %0d status %0d, got read %h fill %0d status %0d",
                     exp_res.rd, exp_res.fill, exp_res.st, read_value, fill_count, status);
        end
      end
    end
  end

  // watchdog on cycles with no request taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // after reset, extremes, every operation and the empty and out-of-range rejections
    add_row(OP_GET,    0,   32'h0000_0005, 1, 32'h0, 0, STAT_EMPTY);
    add_row(OP_SET,    0,   32'h0000_0005, 1, 32'h0, 0, STAT_EMPTY);
    add_row(OP_REMOVE, 0,   32'h0,         1, 32'h0, 0, STAT_EMPTY);
    add_row(OP_INSERT, 1,   32'h0000_0001, 1, 32'h0, 0, STAT_RANGE);
    add_row(OP_INSERT, 0,   32'h7FFF_FFFF, 1, 32'h0, 1, STAT_OK);
    add_row(OP_INSERT, 1,   32'h8000_0000, 1, 32'h0, 2, STAT_OK);
    add_row(OP_INSERT, 0,   32'hFFFF_FFFF, 1, 32'h0, 3, STAT_OK);
    add_row(OP_GET,    0,   32'h0,         1, 32'hFFFF_FFFF, 3, STAT_OK);
    add_row(OP_GET,    2,   32'h0,         0, 32'h0, 0, STAT_OK);
    add_row(OP_GET,    3,   32'h0,         1, 32'h0, 3, STAT_RANGE);
    add_row(OP_GET,    127, 32'h0,         1, 32'h0, 3, STAT_RANGE);
    add_row(OP_SET,    1,   32'h1234_5678, 0, 32'h0, 0, STAT_OK);
    add_row(OP_GET,    1,   32'h0,         0, 32'h0, 0, STAT_OK);
    add_row(OP_INSERT, 3,   32'h0000_0000, 0, 32'h0, 0, STAT_OK);
    add_row(OP_INSERT, 1,   32'hA5A5_A5A5, 0, 32'h0, 0, STAT_OK);
    add_row(OP_INSERT, 6,   32'h0000_0007, 1, 32'h0, 5, STAT_RANGE);
    add_row(OP_REMOVE, 0,   32'h0,         0, 32'h0, 0, STAT_OK);
    add_row(OP_REMOVE, 3,   32'h0,         0, 32'h0, 0, STAT_OK);
    add_row(OP_REMOVE, 99,  32'h0,         1, 32'h0, 3, STAT_RANGE);
    add_row(OP_SET,    2,   32'h0000_0000, 0, 32'h0, 0, STAT_OK);
    add_row(OP_REMOVE, 1,   32'h0,         0, 32'h0, 0, STAT_OK);
    add_row(OP_REMOVE, 1,   32'h0,         0, 32'h0, 0, STAT_OK);
    add_row(OP_REMOVE, 0,   32'h0,         0, 32'h0, 0, STAT_OK);
    add_row(OP_GET,    0,   32'h0,         1, 32'h0, 0, STAT_EMPTY);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].res);

    // grow until full and keep knocking on the full deque
    random_burst(150, 75, 5);
    // balanced traffic with no idling at all
    idle_enable = 1'b0;
    random_burst(110, 30, 30);
    idle_enable = 1'b1;
    // drain until empty and poke the empty deque
    random_burst(110, 5, 75);
    random_burst(30, 35, 35);

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: get %0d, set %0d, insert %0d, remove %0d; peak fill %0d of %0d",
             op_hits[OP_GET], op_hits[OP_SET], op_hits[OP_INSERT], op_hits[OP_REMOVE],
             peak_count, CAPACITY);
    $display("answers: ok %0d, out of range %0d, full %0d, empty %0d; errors %0d",
             status_hits[STAT_OK], status_hits[STAT_RANGE], status_hits[STAT_FULL],
             status_hits[STAT_EMPTY], error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
